### design/lbe_pkg.sv
// shared types, constants and arctangent table for the light bar endpoint pipeline
package lbe_pkg;

	// field widths
	localparam int COORD_W = 16;
	localparam int ANG_W   = 14;
	localparam int PIX_W   = 14;

	// cordic datapath widths: x, y in Q.30, z in 2^-16 degree
	localparam int XY_W    = 33;
	localparam int Z_W     = 25;
	localparam int THETA_W = 13;
	localparam int PROD_W  = XY_W + COORD_W;
	localparam int PT_W    = 50;
	localparam int MAX_STAGES = 24;

	// angle constants in 1/64 degree
	localparam int ANG_90  = 5760;
	localparam int ANG_180 = 11520;

	// start value of x: cordic gain in Q.30
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

	// saturation limits of an end point
	localparam int PIX_MAX = 8191;
	localparam int PIX_MIN = -8192;

	// rectangle travelling along the pipeline
	typedef struct packed {
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [COORD_W-1:0] norm_width;
		logic [COORD_W-1:0] norm_height;
		logic [ANG_W-1:0]   norm_angle;
		logic               mirror;
	} item_t;

	// rotation state of one cordic cell
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} rot_t;

	// one result transaction
	typedef struct packed {
		logic [PIX_W-1:0]   bottom_y;
		logic [PIX_W-1:0]   bottom_x;
		logic [PIX_W-1:0]   top_y;
		logic [PIX_W-1:0]   top_x;
		logic [ANG_W-1:0]   norm_angle;
		logic [COORD_W-1:0] norm_height;
		logic [COORD_W-1:0] norm_width;
	} result_t;

	// atan(2^-i) degrees * 65536, rounded
	function automatic logic [Z_W-1:0] atan_at(input logic [4:0] idx);
		logic [Z_W-1:0] v;
		case (idx)
			5'd0:    v = Z_W'(2949120);
			5'd1:    v = Z_W'(1740967);
			5'd2:    v = Z_W'(919879);
			5'd3:    v = Z_W'(466945);
			5'd4:    v = Z_W'(234379);
			5'd5:    v = Z_W'(117304);
			5'd6:    v = Z_W'(58666);
			5'd7:    v = Z_W'(29335);
			5'd8:    v = Z_W'(14668);
			5'd9:    v = Z_W'(7334);
			5'd10:   v = Z_W'(3667);
			5'd11:   v = Z_W'(1833);
			5'd12:   v = Z_W'(917);
			5'd13:   v = Z_W'(458);
			5'd14:   v = Z_W'(229);
			5'd15:   v = Z_W'(115);
			5'd16:   v = Z_W'(57);
			5'd17:   v = Z_W'(29);
			5'd18:   v = Z_W'(14);
			5'd19:   v = Z_W'(7);
			5'd20:   v = Z_W'(4);
			5'd21:   v = Z_W'(2);
			5'd22:   v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	// clamp a shifted point to the 14 bit pixel range
	function automatic logic [PIX_W-1:0] sat_pix(input logic signed [PT_W-1:0] v);
		logic [PIX_W-1:0] r;
		if (v > PT_W'(PIX_MAX))
			r = PIX_W'(PIX_MAX);
		else if (v < PT_W'(PIX_MIN))
			r = PIX_W'(PIX_MIN);
		else
			r = v[PIX_W-1:0];
		return r;
	endfunction

endpackage

### design/lbe_norm.sv
// input stage: side swap, angle wrap and mirror, cordic start value
module lbe_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       center_x,
	input  logic [15:0]       center_y,
	input  logic [15:0]       box_width,
	input  logic [15:0]       box_height,
	input  logic [13:0]       box_angle,
	output logic              out_valid,
	input  logic              out_ready,
	output lbe_pkg::item_t    out_item,
	output lbe_pkg::rot_t     out_rot
);

	logic                          valid_s1;
	lbe_pkg::item_t                item_s1;
	lbe_pkg::rot_t                 rot_s1;
	logic                          swap;
	logic signed [14:0]            ang_in;
	logic signed [14:0]            ang_sw;
	logic signed [14:0]            ang_n;
	logic                          mirror;
	logic [lbe_pkg::THETA_W-1:0]   theta;
	lbe_pkg::item_t                item_d;
	lbe_pkg::rot_t                 rot_d;

	assign in_ready = !valid_s1 || out_ready;

	// normalize sides and angle
	always_comb begin
		swap   = box_width > box_height;
		ang_in = 15'($signed(box_angle));
		if (swap)
			ang_sw = (ang_in >= 15'sd0) ? ang_in - 15'(lbe_pkg::ANG_90)
				: ang_in + 15'(lbe_pkg::ANG_90);
		else
			ang_sw = ang_in;
		ang_n  = (ang_sw < 15'sd0) ? ang_sw + 15'(lbe_pkg::ANG_180) : ang_sw;
		mirror = ang_n >= 15'(lbe_pkg::ANG_90);
		theta  = mirror ? lbe_pkg::THETA_W'(15'(lbe_pkg::ANG_180) - ang_n)
			: lbe_pkg::THETA_W'(ang_n);

		item_d.center_x    = center_x;
		item_d.center_y    = center_y;
		item_d.norm_width  = swap ? box_height : box_width;
		item_d.norm_height = swap ? box_width : box_height;
		item_d.norm_angle  = ang_n[13:0];
		item_d.mirror      = mirror;

		rot_d.x = lbe_pkg::CORDIC_GAIN;
		rot_d.y = '0;
		rot_d.z = $signed({2'b00, theta, 10'b0});
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
			rot_s1  <= rot_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;
	assign out_rot   = rot_s1;

endmodule

### design/lbe_cordic_cell.sv
// one cordic rotation cell with its own handshake stage
module lbe_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lbe_pkg::item_t in_item,
	input  lbe_pkg::rot_t  in_rot,
	output logic           out_valid,
	input  logic           out_ready,
	output lbe_pkg::item_t out_item,
	output lbe_pkg::rot_t  out_rot
);

	logic                               valid_q;
	lbe_pkg::item_t                     item_q;
	lbe_pkg::rot_t                      rot_q;
	logic signed [lbe_pkg::XY_W-1:0]    xs;
	logic signed [lbe_pkg::XY_W-1:0]    ys;
	logic signed [lbe_pkg::Z_W-1:0]     atan;
	lbe_pkg::rot_t                      rot_d;

	assign in_ready = !valid_q || out_ready;

	// micro rotation toward z = 0
	always_comb begin
		xs   = in_rot.x >>> STAGE;
		ys   = in_rot.y >>> STAGE;
		atan = $signed(lbe_pkg::atan_at(5'(STAGE)));
		if (in_rot.z >= 0) begin
			rot_d.x = in_rot.x - ys;
			rot_d.y = in_rot.y + xs;
			rot_d.z = in_rot.z - atan;
		end else begin
			rot_d.x = in_rot.x + ys;
			rot_d.y = in_rot.y - xs;
			rot_d.z = in_rot.z + atan;
		end
	end

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= in_item;
			rot_q  <= rot_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;
	assign out_rot   = rot_q;

endmodule

### design/lbe_endpoint.sv
// scales sine and cosine by half the long side and rounds the two end points
module lbe_endpoint #(
	parameter int FRAC_BITS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lbe_pkg::item_t   in_item,
	input  lbe_pkg::rot_t    in_rot,
	output logic             out_valid,
	input  logic             out_ready,
	output lbe_pkg::result_t out_res
);

	localparam int PT_W  = lbe_pkg::PT_W;
	localparam int SHIFT = FRAC_BITS + 31;
	localparam logic signed [PT_W-1:0] HALF = PT_W'(1) << (FRAC_BITS + 30);

	logic                                valid_s1;
	logic                                valid_s2;
	logic                                ready_s2;
	lbe_pkg::item_t                      item_s1;
	logic signed [lbe_pkg::PROD_W-1:0]   ds_s1;
	logic signed [lbe_pkg::PROD_W-1:0]   dc_s1;
	lbe_pkg::result_t                    res_s2;
	logic signed [PT_W-1:0]              bx;
	logic signed [PT_W-1:0]              by;
	logic signed [PT_W-1:0]              ds;
	logic signed [PT_W-1:0]              dc;
	logic signed [PT_W-1:0]              px_plus;
	logic signed [PT_W-1:0]              px_minus;
	logic signed [PT_W-1:0]              py_minus;
	logic signed [PT_W-1:0]              py_plus;
	lbe_pkg::result_t                    res_d;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	// multiply stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// half height times sine and cosine, operands widened to the product width
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
			ds_s1   <= $signed({{(lbe_pkg::PROD_W - lbe_pkg::COORD_W){1'b0}},
				in_item.norm_height}) * lbe_pkg::PROD_W'(in_rot.y);
			dc_s1   <= $signed({{(lbe_pkg::PROD_W - lbe_pkg::COORD_W){1'b0}},
				in_item.norm_height}) * lbe_pkg::PROD_W'(in_rot.x);
		end
	end

	// center offsets with round half up
	always_comb begin
		bx = $signed({{(PT_W - 16){1'b0}}, item_s1.center_x}) <<< 31;
		by = $signed({{(PT_W - 16){1'b0}}, item_s1.center_y}) <<< 31;
		ds = PT_W'(ds_s1);
		dc = PT_W'(dc_s1);
		px_plus  = (bx + ds + HALF) >>> SHIFT;
		px_minus = (bx - ds + HALF) >>> SHIFT;
		py_minus = (by - dc + HALF) >>> SHIFT;
		py_plus  = (by + dc + HALF) >>> SHIFT;

		res_d.norm_width  = item_s1.norm_width;
		res_d.norm_height = item_s1.norm_height;
		res_d.norm_angle  = item_s1.norm_angle;
		res_d.top_x    = lbe_pkg::sat_pix(item_s1.mirror ? px_minus : px_plus);
		res_d.bottom_x = lbe_pkg::sat_pix(item_s1.mirror ? px_plus : px_minus);
		res_d.top_y    = lbe_pkg::sat_pix(py_minus);
		res_d.bottom_y = lbe_pkg::sat_pix(py_plus);
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (ready_s2)
			valid_s2 <= valid_s1;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1)
			res_s2 <= res_d;
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

endmodule

### design/light_bar_endpoints.sv
// light bar normalization and end point pipeline, top level
// registered stages from input transaction to result valid: one normalize stage,
// one cordic cell per rotation, a multiply and a round stage
// throughput: one transaction per cycle unless the output stalls; each stage has
// its own valid and the ready chain fills any empty stage even while a result waits
// reset: arst_n clears all stage valid bits at once, payload registers keep no reset
module light_bar_endpoints #(
	parameter int FRAC_BITS     = 4,
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// center_x[15:0], center_y[31:16], box_width[47:32], box_height[63:48],
	// box_angle[77:64], zero[79:78]
	input  logic [79:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// norm_width[15:0], norm_height[31:16], norm_angle[45:32], top_x[59:46],
	// top_y[73:60], bottom_x[87:74], bottom_y[101:88], zero[103:102]
	output logic [103:0] m_axis_tdata
);

	logic             cv [CORDIC_STAGES+1];
	logic             cr [CORDIC_STAGES+1];
	lbe_pkg::item_t   ci [CORDIC_STAGES+1];
	lbe_pkg::rot_t    cs [CORDIC_STAGES+1];
	lbe_pkg::result_t res;

	// front end
	lbe_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.center_x   (s_axis_tdata[15:0]),
		.center_y   (s_axis_tdata[31:16]),
		.box_width  (s_axis_tdata[47:32]),
		.box_height (s_axis_tdata[63:48]),
		.box_angle  (s_axis_tdata[77:64]),
		.out_valid  (cv[0]),
		.out_ready  (cr[0]),
		.out_item   (ci[0]),
		.out_rot    (cs[0])
	);

	// chain of cordic cells
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		lbe_cordic_cell #(
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (cr[i]),
			.in_item   (ci[i]),
			.in_rot    (cs[i]),
			.out_valid (cv[i+1]),
			.out_ready (cr[i+1]),
			.out_item  (ci[i+1]),
			.out_rot   (cs[i+1])
		);
	end

	// scaling, rounding and output register
	lbe_endpoint #(
		.FRAC_BITS (FRAC_BITS)
	) u_endpoint (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv[CORDIC_STAGES]),
		.in_ready  (cr[CORDIC_STAGES]),
		.in_item   (ci[CORDIC_STAGES]),
		.in_rot    (cs[CORDIC_STAGES]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {2'b00, res};

	// an empty output register means every stage can take a transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output register empty");

	// normalized angle stays below 180 degrees
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.norm_angle < 14'(lbe_pkg::ANG_180)))
		else $error("normalized angle out of range");

	// long side is never shorter than the short side
	a_sides_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.norm_width <= res.norm_height))
		else $error("sides not ordered after normalization");

endmodule

### tb/light_bar_endpoints_tb.sv
// testbench for the light bar end point pipeline: directed table, random rectangles, predictor
module light_bar_endpoints_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS     = 4;
	localparam int CORDIC_STAGES = 16;
	localparam int LATENCY       = CORDIC_STAGES + 3;
	localparam int N_DIRECTED    = 22;
	localparam int N_RANDOM      = 600;

	// atan(2^-i) in 2^-16 degree
	localparam longint ARCTAN_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// one rectangle, packed as it travels in s_axis_tdata (last field lowest)
	typedef struct packed {
		logic signed [lbe_pkg::ANG_W-1:0] ang;
		logic [lbe_pkg::COORD_W-1:0]      h;
		logic [lbe_pkg::COORD_W-1:0]      w;
		logic [lbe_pkg::COORD_W-1:0]      cy;
		logic [lbe_pkg::COORD_W-1:0]      cx;
	} box_t;

	// one set of end points, packed as in m_axis_tdata
	typedef struct packed {
		logic [lbe_pkg::PIX_W-1:0]   bottom_y;
		logic [lbe_pkg::PIX_W-1:0]   bottom_x;
		logic [lbe_pkg::PIX_W-1:0]   top_y;
		logic [lbe_pkg::PIX_W-1:0]   top_x;
		logic [lbe_pkg::ANG_W-1:0]   norm_angle;
		logic [lbe_pkg::COORD_W-1:0] norm_height;
		logic [lbe_pkg::COORD_W-1:0] norm_width;
	} ends_t;

	// directed row: rectangle, and the end points where they are obvious
	typedef struct {
		int cx, cy, w, h, ang;
		bit typed;
		int nw, nh, na, tx, ty, bx, by;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [79:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;

	ends_t ends_pending [$];
	int    errors;
	int    boxes_sent;
	int    ends_checked;
	int    swaps;
	int    hold_cycles;
	bit    calm;

	stim_row_t directed [N_DIRECTED] = '{
		'{0,     0,     0,     0,     0,     1, 0, 0, 0,    0,    0,    0,    0},
		'{8,     24,    0,     0,     0,     1, 0, 0, 0,    1,    2,    1,    2},
		'{65535, 65535, 0,     0,     -5760, 1, 0, 0, 5760, 4096, 4096, 4096, 4096},
		'{160,   160,   0,     32,    0,     0, 0, 0, 0,    0,    0,    0,    0},
		'{65535, 65535, 0,     65535, 5760,  0, 0, 0, 0,    0,    0,    0,    0},
		'{0,     0,     0,     65535, 0,     0, 0, 0, 0,    0,    0,    0,    0},
		'{0,     0,     65535, 65535, 1234,  0, 0, 0, 0,    0,    0,    0,    0},
		'{1600,  1600,  1000,  1000,  -1234, 0, 0, 0, 0,    0,    0,    0,    0},
		'{3200,  4800,  5000,  100,   1000,  0, 0, 0, 0,    0,    0,    0,    0},
		'{3200,  4800,  5000,  100,   -1000, 0, 0, 0, 0,    0,    0,    0,    0},
		'{3200,  4800,  5000,  100,   0,     0, 0, 0, 0,    0,    0,    0,    0},
		'{32768, 32768, 100,   4000,  -1,    0, 0, 0, 0,    0,    0,    0,    0},
		'{32768, 32768, 100,   4000,  1,     0, 0, 0, 0,    0,    0,    0,    0},
		'{32768, 32768, 100,   4000,  5759,  0, 0, 0, 0,    0,    0,    0,    0},
		'{32768, 32768, 100,   4000,  -5759, 0, 0, 0, 0,    0,    0,    0,    0},
		'{32768, 32768, 100,   4000,  5760,  0, 0, 0, 0,    0,    0,    0,    0},
		'{32768, 32768, 100,   4000,  8191,  0, 0, 0, 0,    0,    0,    0,    0},
		'{32768, 32768, 100,   4000,  -8192, 0, 0, 0, 0,    0,    0,    0,    0},
		'{65535, 0,     65535, 0,     -8192, 0, 0, 0, 0,    0,    0,    0,    0},
		'{0,     65535, 65535, 1,     8191,  0, 0, 0, 0,    0,    0,    0,    0},
		'{21845, 43690, 43690, 21845, 2880,  0, 0, 0, 0,    0,    0,    0,    0},
		'{43690, 21845, 21845, 43690, -2881, 0, 0, 0, 0,    0,    0,    0,    0}
	};

	light_bar_endpoints #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// round half up to whole pixels and clamp to 14 bits
	function automatic logic [lbe_pkg::PIX_W-1:0] to_pixel(input longint v);
		longint p;
		p = (v + (longint'(1) << (FRAC_BITS + 30))) >>> (FRAC_BITS + 31);
		if (p > lbe_pkg::PIX_MAX)
			p = lbe_pkg::PIX_MAX;
		if (p < lbe_pkg::PIX_MIN)
			p = lbe_pkg::PIX_MIN;
		return lbe_pkg::PIX_W'(p);
	endfunction

	// normalize the rectangle and rotate the half long side
	function automatic ends_t predict_ends(input box_t b);
		longint w, h, a, t, theta, x, y, z, xs, ys, ds, dc, px, py;
		bit     mirror;
		int     i;
		ends_t  r;
		w = b.w;
		h = b.h;
		a = b.ang;
		if (w > h) begin
			t = w;
			w = h;
			h = t;
			a = (a >= 0) ? a - lbe_pkg::ANG_90 : a + lbe_pkg::ANG_90;
		end
		if (a < 0)
			a += lbe_pkg::ANG_180;
		mirror = (a >= lbe_pkg::ANG_90);
		theta = mirror ? lbe_pkg::ANG_180 - a : a;

		// cordic rotation from the gain-corrected unit vector
		x = longint'(lbe_pkg::CORDIC_GAIN);
		y = 0;
		z = theta * 1024;
		for (i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= ARCTAN_Q16[i];
			end else begin
				x += ys;
				y -= xs;
				z += ARCTAN_Q16[i];
			end
		end

		ds = h * y;
		dc = h * x;
		px = longint'(b.cx) << 31;
		py = longint'(b.cy) << 31;
		r.norm_width  = lbe_pkg::COORD_W'(w);
		r.norm_height = lbe_pkg::COORD_W'(h);
		r.norm_angle  = lbe_pkg::ANG_W'(a);
		r.top_x       = to_pixel(mirror ? px - ds : px + ds);
		r.bottom_x    = to_pixel(mirror ? px + ds : px - ds);
		r.top_y       = to_pixel(py - dc);
		r.bottom_y    = to_pixel(py + dc);
		return r;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// result side: compare each transaction with the oldest expectation
	always @(posedge clk) begin
		ends_t got;
		ends_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = ends_t'(m_axis_tdata[$bits(ends_t)-1:0]);
			hold_cycles = calm ? 0 : $urandom_range(0, 5);
			if (ends_pending.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual %h",
					$time, got);
				errors++;
			end else begin
				want = ends_pending.pop_front();
				check_field("norm_width", want.norm_width, got.norm_width);
				check_field("norm_height", want.norm_height, got.norm_height);
				check_field("norm_angle", want.norm_angle, got.norm_angle);
				check_field("top_x", $signed(want.top_x), $signed(got.top_x));
				check_field("top_y", $signed(want.top_y), $signed(got.top_y));
				check_field("bottom_x", $signed(want.bottom_x), $signed(got.bottom_x));
				check_field("bottom_y", $signed(want.bottom_y), $signed(got.bottom_y));
				ends_checked++;
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready = 1'b0;
			hold_cycles--;
		end else begin
			m_axis_tready = arst_n;
		end
	end

	// drive one rectangle and queue what it should produce
	task automatic send_box(input box_t b, input bit typed, input ends_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {2'b00, b};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		ends_pending = {ends_pending, (typed ? want : predict_ends(b))};
		boxes_sent++;
		if (b.w > b.h)
			swaps++;
		@(negedge clk);
	endtask

	// hold the source until every queued result has come back
	task automatic wait_for_ends();
		s_axis_tvalid = 1'b0;
		while (ends_pending.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic box_t random_box();
		box_t b;
		int   pick;
		b.cx = lbe_pkg::COORD_W'($urandom);
		b.cy = lbe_pkg::COORD_W'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			b.w = lbe_pkg::COORD_W'($urandom_range(0, 2047));
			b.h = lbe_pkg::COORD_W'($urandom_range(0, 2047));
		end else begin
			b.w = lbe_pkg::COORD_W'($urandom);
			b.h = lbe_pkg::COORD_W'($urandom);
		end
		if (pick == 9)
			b.w = b.h;
		pick = $urandom_range(0, 9);
		if (pick < 8) begin
			b.ang = lbe_pkg::ANG_W'(int'($urandom_range(0, 2 * lbe_pkg::ANG_90))
				- lbe_pkg::ANG_90);
		end else if (pick == 8) begin
			b.ang = lbe_pkg::ANG_W'($urandom);
		end else begin
			// angles on the swap and wrap boundaries
			case ($urandom_range(0, 5))
				0:       b.ang = lbe_pkg::ANG_W'(lbe_pkg::ANG_90);
				1:       b.ang = lbe_pkg::ANG_W'(-lbe_pkg::ANG_90);
				2:       b.ang = lbe_pkg::ANG_W'(lbe_pkg::ANG_90 - 1);
				3:       b.ang = lbe_pkg::ANG_W'(1 - lbe_pkg::ANG_90);
				4:       b.ang = lbe_pkg::ANG_W'(-1);
				default: b.ang = '0;
			endcase
		end
		return b;
	endfunction

	// stimulus
	initial begin
		box_t  b;
		ends_t want;
		int    n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		hold_cycles   = 0;
		calm          = 1'b0;
		errors        = 0;
		boxes_sent    = 0;
		ends_checked  = 0;
		swaps         = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (n = 0; n < N_DIRECTED; n++) begin
			b.cx  = lbe_pkg::COORD_W'(directed[n].cx);
			b.cy  = lbe_pkg::COORD_W'(directed[n].cy);
			b.w   = lbe_pkg::COORD_W'(directed[n].w);
			b.h   = lbe_pkg::COORD_W'(directed[n].h);
			b.ang = lbe_pkg::ANG_W'(directed[n].ang);
			want.norm_width  = lbe_pkg::COORD_W'(directed[n].nw);
			want.norm_height = lbe_pkg::COORD_W'(directed[n].nh);
			want.norm_angle  = lbe_pkg::ANG_W'(directed[n].na);
			want.top_x       = lbe_pkg::PIX_W'(directed[n].tx);
			want.top_y       = lbe_pkg::PIX_W'(directed[n].ty);
			want.bottom_x    = lbe_pkg::PIX_W'(directed[n].bx);
			want.bottom_y    = lbe_pkg::PIX_W'(directed[n].by);
			send_box(b, directed[n].typed, want);
		end
		wait_for_ends();

		// random rectangles, with back-to-back stretches now and then
		want = '0;
		for (n = 0; n < N_RANDOM; n++) begin
			if (n % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (n == N_RANDOM / 2)
				wait_for_ends();
			send_box(random_box(), 1'b0, want);
		end
		s_axis_tvalid = 1'b0;
		calm = 1'b0;

		wait_for_ends();
		repeat (3 * LATENCY) @(posedge clk);
		$display("summary: %0d rectangles sent (%0d with sides swapped), %0d end point sets checked",
			boxes_sent, swaps, ends_checked);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", ends_pending.size());
		$display("tb: failure");
		$finish;
	end

endmodule
